// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the status packet deframer RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SDF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sdf_pkg.sv
// Package for the status packet deframer: phase and control encodings,
// status codes, the parameter buffer command struct. No dependencies.
package sdf_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [5:0] LIMIT_RESET = 6'd58;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADSUM = 2'd1;
    localparam logic [1:0] ST_LONG   = 2'd2;
    localparam logic [1:0] ST_SHORT  = 2'd3;

    // Position within the packet being framed.
    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_HDR,
        PH_LEN,
        PH_ERR,
        PH_PARAM,
        PH_CHK
    } t_phase;

    // Sequencer of the top level.
    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_PROC,
        CTL_RES,
        CTL_RD,
        CTL_WAIT
    } t_ctl;

    // Strobes from the sequencer to the parameter buffer.
    typedef struct packed {
        logic we;
        logic re;
    } t_buf_cmd;

endpackage

// File: hw/rtl/sdf_param_buf.sv
// Parameter byte buffer of the status packet deframer: one write port and
// one read port with registered read data. Depends on sdf_pkg.
module sdf_param_buf #(
    parameter int DEPTH  = 58,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  sdf_pkg::t_buf_cmd i_cmd,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read strobe.
    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/status_packet_deframer.sv
// Top level of the status packet deframer: byte sequencer, checksum and
// result register. Depends on sdf_pkg, sdf_param_buf and assert_macros.svh.
//
//  Channel   Direction  Handshake               Payload
//  input     in         i_in_valid/o_in_stall   i_rx_byte
//  result    out        o_out_valid/i_out_stall servo_id ... last (eight fields)
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (param_limit)
//
// A received word is accepted in CTL_IDLE and processed in CTL_PROC. A word
// that ends a packet with a single result then passes through CTL_RES, which
// loads it. A good packet hands out each parameter through the one read port
// of the parameter buffer: CTL_RD reads it, CTL_WAIT loads its registered data.
// Reset is synchronous and active low; the buffer is not cleared, since only
// entries written in the current packet are ever read. A result waiting in the
// result register does not stall the input: words keep being taken until one
// closes a result, which then holds the sequencer, and the input with it,
// until the result register frees.
`include "assert_macros.svh"

module status_packet_deframer #(
    parameter int PACKET_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received bus words.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // Results.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_servo_id,
    output logic [7:0] o_error_flags,
    output logic [5:0] o_param_count,
    output logic [1:0] o_status,
    output logic       o_param_valid,
    output logic [5:0] o_param_index,
    output logic [7:0] o_param_byte,
    output logic       o_last,
    // Configuration: param_limit.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    // Largest accepted LEN and the number of parameter bytes it allows.
    localparam int MAX_LEN     = PACKET_BYTES - 4;
    localparam int STORE_DEPTH = PACKET_BYTES - 6;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // Common width for comparing and truncating counts against 6-bit fields.
    localparam int GW          = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_LEN);

    // Sequencer and packet state.
    sdf_pkg::t_ctl     r_ctl, n_ctl;
    sdf_pkg::t_phase   r_phase, n_phase;
    logic [7:0]        r_pkt_id, n_pkt_id;
    logic [LEN_W-1:0]  r_pkt_len, n_pkt_len;
    logic [7:0]        r_pkt_err, n_pkt_err;
    logic [7:0]        r_sum, n_sum;
    logic [CNT_W-1:0]  r_taken, n_taken;
    logic [5:0]        r_limit;
    logic [7:0]        r_byte;

    // Result bookkeeping.
    logic [1:0]        r_res_status, n_res_status;
    logic [CNT_W-1:0]  r_give;
    logic [CNT_W-1:0]  r_idx;

    // Result register.
    logic              r_out_valid;
    logic [7:0]        r_out_id;
    logic [7:0]        r_out_err;
    logic [5:0]        r_out_count;
    logic [1:0]        r_out_status;
    logic              r_out_pvalid;
    logic [5:0]        r_out_pidx;
    logic [7:0]        r_out_pbyte;
    logic              r_out_last;

    logic [7:0]        n_out_err;
    logic [5:0]        n_out_count;
    logic [1:0]        n_out_status;
    logic              n_out_pvalid;
    logic [5:0]        n_out_pidx;
    logic [7:0]        n_out_pbyte;
    logic              n_out_last;

    logic              in_acc;
    logic              slot_free;
    logic              out_load;
    logic              res_one;
    logic              res_many;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  taken_inc;
    logic [GW-1:0]     cnt_g;
    logic [GW-1:0]     lim_g;
    logic [GW-1:0]     give_g;
    logic [CNT_W-1:0]  give;
    logic [GW-1:0]     idx_g;
    logic [CNT_W-1:0]  idx_inc;
    logic              idx_last;

    sdf_pkg::t_buf_cmd buf_cmd;
    logic [7:0]        buf_rdata;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    // LEN minus two, or zero before any length was taken.
    assign count     = (r_pkt_len >= LEN_W'(2)) ? CNT_W'(r_pkt_len - LEN_W'(2)) : '0;
    assign taken_inc = r_taken + CNT_W'(1);

    // Parameters handed out: the smaller of the count and the limit. The count
    // never exceeds the buffer depth because LEN is bounded on arrival.
    assign cnt_g  = GW'(count);
    assign lim_g  = GW'(r_limit);
    assign give_g = (cnt_g < lim_g) ? cnt_g : lim_g;
    assign give   = CNT_W'(give_g);

    assign idx_g    = GW'(r_idx);
    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_last = (idx_inc == r_give);

    // Framing of the word held in r_byte; the results apply in CTL_PROC only.
    always_comb begin
        n_phase      = r_phase;
        n_pkt_id     = r_pkt_id;
        n_pkt_len    = r_pkt_len;
        n_pkt_err    = r_pkt_err;
        n_sum        = r_sum;
        n_taken      = r_taken;
        n_res_status = sdf_pkg::ST_OK;
        res_one      = 1'b0;
        res_many     = 1'b0;
        case (r_phase)
            sdf_pkg::PH_HUNT0: begin
                if (r_byte == sdf_pkg::HDR_BYTE) begin
                    n_phase = sdf_pkg::PH_HUNT1;
                end
            end
            sdf_pkg::PH_HUNT1: begin
                n_phase = (r_byte == sdf_pkg::HDR_BYTE) ? sdf_pkg::PH_HDR
                                                        : sdf_pkg::PH_HUNT0;
            end
            sdf_pkg::PH_HDR: begin
                // Extra FF words after the header are skipped.
                if (r_byte != sdf_pkg::HDR_BYTE) begin
                    n_pkt_id = r_byte;
                    n_sum    = r_byte;
                    n_phase  = sdf_pkg::PH_LEN;
                end
            end
            sdf_pkg::PH_LEN: begin
                if (r_byte > MAX_LEN_B) begin
                    n_res_status = sdf_pkg::ST_LONG;
                    res_one      = 1'b1;
                    n_phase      = sdf_pkg::PH_HUNT0;
                end else if (r_byte < 8'd2) begin
                    n_res_status = sdf_pkg::ST_SHORT;
                    res_one      = 1'b1;
                    n_phase      = sdf_pkg::PH_HUNT0;
                end else begin
                    n_pkt_len = LEN_W'(r_byte);
                    n_sum     = r_sum + r_byte;
                    n_phase   = sdf_pkg::PH_ERR;
                end
            end
            sdf_pkg::PH_ERR: begin
                n_pkt_err = r_byte;
                n_sum     = r_sum + r_byte;
                n_taken   = '0;
                n_phase   = (count != '0) ? sdf_pkg::PH_PARAM : sdf_pkg::PH_CHK;
            end
            sdf_pkg::PH_PARAM: begin
                n_sum   = r_sum + r_byte;
                n_taken = taken_inc;
                if (taken_inc >= count) begin
                    n_phase = sdf_pkg::PH_CHK;
                end
            end
            sdf_pkg::PH_CHK: begin
                if (~r_sum != r_byte) begin
                    n_res_status = sdf_pkg::ST_BADSUM;
                    res_one      = 1'b1;
                end else if (give == '0) begin
                    res_one = 1'b1;
                end else begin
                    res_many = 1'b1;
                end
                n_phase = sdf_pkg::PH_HUNT0;
            end
            default: begin
                n_phase = sdf_pkg::PH_HUNT0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            sdf_pkg::CTL_IDLE: begin
                if (in_acc) begin
                    n_ctl = sdf_pkg::CTL_PROC;
                end
            end
            sdf_pkg::CTL_PROC: begin
                if (res_many) begin
                    n_ctl = sdf_pkg::CTL_RD;
                end else if (res_one) begin
                    n_ctl = sdf_pkg::CTL_RES;
                end else begin
                    n_ctl = sdf_pkg::CTL_IDLE;
                end
            end
            sdf_pkg::CTL_RES: begin
                if (slot_free) begin
                    n_ctl = sdf_pkg::CTL_IDLE;
                end
            end
            sdf_pkg::CTL_RD: begin
                n_ctl = sdf_pkg::CTL_WAIT;
            end
            sdf_pkg::CTL_WAIT: begin
                if (slot_free) begin
                    n_ctl = idx_last ? sdf_pkg::CTL_IDLE : sdf_pkg::CTL_RD;
                end
            end
            default: begin
                n_ctl = sdf_pkg::CTL_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input stall, buffer strobes and the result to load.
    always_comb begin
        o_in_stall   = (r_ctl != sdf_pkg::CTL_IDLE);
        buf_cmd.we   = (r_ctl == sdf_pkg::CTL_PROC) && (r_phase == sdf_pkg::PH_PARAM);
        buf_cmd.re   = (r_ctl == sdf_pkg::CTL_RD);
        out_load     = 1'b0;
        n_out_err    = r_pkt_err;
        n_out_count  = cnt_g[5:0];
        n_out_status = r_res_status;
        n_out_pvalid = 1'b0;
        n_out_pidx   = '0;
        n_out_pbyte  = '0;
        n_out_last   = 1'b1;
        case (r_ctl)
            sdf_pkg::CTL_RES: begin
                out_load = slot_free;
                // Length errors report no count and no error byte.
                if (r_res_status == sdf_pkg::ST_LONG || r_res_status == sdf_pkg::ST_SHORT) begin
                    n_out_err   = '0;
                    n_out_count = '0;
                end
            end
            sdf_pkg::CTL_WAIT: begin
                out_load     = slot_free;
                n_out_status = sdf_pkg::ST_OK;
                n_out_pvalid = 1'b1;
                n_out_pidx   = idx_g[5:0];
                n_out_pbyte  = buf_rdata;
                n_out_last   = idx_last;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= sdf_pkg::CTL_IDLE;
            r_phase   <= sdf_pkg::PH_HUNT0;
            r_pkt_id  <= '0;
            r_pkt_len <= '0;
            r_pkt_err <= '0;
            r_sum     <= '0;
            r_taken   <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (r_ctl == sdf_pkg::CTL_PROC) begin
                r_phase   <= n_phase;
                r_pkt_id  <= n_pkt_id;
                r_pkt_len <= n_pkt_len;
                r_pkt_err <= n_pkt_err;
                r_sum     <= n_sum;
                r_taken   <= n_taken;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sdf_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_rx_byte;
        end
        if (r_ctl == sdf_pkg::CTL_PROC) begin
            r_res_status <= n_res_status;
            r_give       <= give;
            r_idx        <= '0;
        end else if (r_ctl == sdf_pkg::CTL_WAIT && slot_free) begin
            r_idx <= idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id     <= r_pkt_id;
            r_out_err    <= n_out_err;
            r_out_count  <= n_out_count;
            r_out_status <= n_out_status;
            r_out_pvalid <= n_out_pvalid;
            r_out_pidx   <= n_out_pidx;
            r_out_pbyte  <= n_out_pbyte;
            r_out_last   <= n_out_last;
        end
    end

    // The buffer is never read and written in the same cycle: writes happen
    // while a packet is framed, reads only after its checksum word, with the
    // input stalled.
    sdf_param_buf #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_param_buf (
        .i_clk   (i_clk),
        .i_cmd   (buf_cmd),
        .i_waddr (r_taken[ADDR_W-1:0]),
        .i_wdata (r_byte),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (buf_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_servo_id    = r_out_id;
    assign o_error_flags = r_out_err;
    assign o_param_count = r_out_count;
    assign o_status      = r_out_status;
    assign o_param_valid = r_out_pvalid;
    assign o_param_index = r_out_pidx;
    assign o_param_byte  = r_out_pbyte;
    assign o_last        = r_out_last;

    `SDF_ASSERT(a_load_only_free, out_load |-> slot_free, "result loaded over a waiting result")
    `SDF_ASSERT_NEXT(a_accept_proc, in_acc, r_ctl == sdf_pkg::CTL_PROC, "accepted word not processed")
    `SDF_ASSERT_NEXT(a_last_idle, out_load && n_out_last, r_ctl == sdf_pkg::CTL_IDLE, "sequencer busy after last")
    `SDF_ASSERT(a_read_in_range, (r_ctl == sdf_pkg::CTL_RD) |-> (r_idx < r_give), "parameter read beyond count")

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for status_packet_deframer: directed table plus random packets.
// Depends on sdf_pkg and the status_packet_deframer RTL; reads no files.
`timescale 1ns / 100ps

module tb;

    localparam int FRAME_BYTES    = 64;
    localparam int MAX_LEN        = FRAME_BYTES - 4;
    localparam int STORE_DEPTH    = FRAME_BYTES - 6;
    // Quiet cycles allowed before the run is declared hung. The slowest legal
    // gap is a long run of stalls or idles at 55 percent, far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to let pass after the last result before touching the register:
    // a word that closes no result may still sit in the process register.
    localparam int SETTLE_CYCLES  = 8;
    // Words sent in each random phase, at least.
    localparam int PHASE_WORDS    = 12;

    // One result word of the block, in port order.
    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] error_flags;
        logic [5:0] param_count;
        logic [1:0] status;
        logic       param_valid;
        logic [5:0] param_index;
        logic [7:0] param_byte;
        logic       last;
    } t_deframed;

    // One row of the directed table. When typed is set, want is the single
    // result that this word closes its packet with.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_deframed  want;
    } t_directed_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte   = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_servo_id;
    logic [7:0] o_error_flags;
    logic [5:0] o_param_count;
    logic [1:0] o_status;
    logic       o_param_valid;
    logic [5:0] o_param_index;
    logic [7:0] o_param_byte;
    logic       o_last;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data  = 6'd0;

    status_packet_deframer #(
        .PACKET_BYTES (FRAME_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_servo_id    (o_servo_id),
        .o_error_flags (o_error_flags),
        .o_param_count (o_param_count),
        .o_status      (o_status),
        .o_param_valid (o_param_valid),
        .o_param_index (o_param_index),
        .o_param_byte  (o_param_byte),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the deframer: phase, packet fields, checksum and the
    // parameter store, plus the param_limit register as last written.
    sdf_pkg::t_phase frame_ph = sdf_pkg::PH_HUNT0;
    logic [7:0] frame_id  = 8'd0;
    logic [5:0] frame_len = 6'd0;
    logic [7:0] frame_err = 8'd0;
    logic [7:0] frame_sum = 8'd0;
    logic [5:0] taken     = 6'd0;
    logic [7:0] param_mem [0:STORE_DEPTH-1];
    logic [5:0] limit_shadow = sdf_pkg::LIMIT_RESET;

    // Result words still owed by the block, oldest first.
    t_deframed deframed_q [$];

    t_directed_row directed_rows [$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int misses       = 0;
    int quiet_cycles = 0;

    // Advances the shadow by one accepted word and queues the result words
    // that this word makes the block emit.
    function automatic void deframe_byte(input logic [7:0] b);
        logic [5:0] cnt;
        logic [5:0] give;
        cnt = (frame_len >= 6'd2) ? frame_len - 6'd2 : 6'd0;
        case (frame_ph)
            sdf_pkg::PH_HUNT0: begin
                if (b == sdf_pkg::HDR_BYTE)
                    frame_ph = sdf_pkg::PH_HUNT1;
            end
            sdf_pkg::PH_HUNT1: begin
                frame_ph = (b == sdf_pkg::HDR_BYTE) ? sdf_pkg::PH_HDR : sdf_pkg::PH_HUNT0;
            end
            sdf_pkg::PH_HDR: begin
                // Further header bytes are swallowed; the first other one is the ID.
                if (b != sdf_pkg::HDR_BYTE) begin
                    frame_id  = b;
                    frame_sum = b;
                    frame_ph  = sdf_pkg::PH_LEN;
                end
            end
            sdf_pkg::PH_LEN: begin
                if (b > MAX_LEN) begin
                    deframed_q.push_back('{frame_id, 8'd0, 6'd0, sdf_pkg::ST_LONG,
                                           1'b0, 6'd0, 8'd0, 1'b1});
                    frame_ph = sdf_pkg::PH_HUNT0;
                end else if (b < 8'd2) begin
                    deframed_q.push_back('{frame_id, 8'd0, 6'd0, sdf_pkg::ST_SHORT,
                                           1'b0, 6'd0, 8'd0, 1'b1});
                    frame_ph = sdf_pkg::PH_HUNT0;
                end else begin
                    frame_len = b[5:0];
                    frame_sum = frame_sum + b;
                    frame_ph  = sdf_pkg::PH_ERR;
                end
            end
            sdf_pkg::PH_ERR: begin
                frame_err = b;
                frame_sum = frame_sum + b;
                taken     = 6'd0;
                frame_ph  = (cnt > 6'd0) ? sdf_pkg::PH_PARAM : sdf_pkg::PH_CHK;
            end
            sdf_pkg::PH_PARAM: begin
                param_mem[taken] = b;
                frame_sum = frame_sum + b;
                taken     = taken + 6'd1;
                if (taken >= cnt)
                    frame_ph = sdf_pkg::PH_CHK;
            end
            sdf_pkg::PH_CHK: begin
                if ((frame_sum ^ 8'hFF) != b) begin
                    deframed_q.push_back('{frame_id, frame_err, cnt, sdf_pkg::ST_BADSUM,
                                           1'b0, 6'd0, 8'd0, 1'b1});
                end else begin
                    give = (cnt < limit_shadow) ? cnt : limit_shadow;
                    if (give == 6'd0) begin
                        deframed_q.push_back('{frame_id, frame_err, cnt, sdf_pkg::ST_OK,
                                               1'b0, 6'd0, 8'd0, 1'b1});
                    end else begin
                        for (int i = 0; i < give; i++)
                            deframed_q.push_back('{frame_id, frame_err, cnt, sdf_pkg::ST_OK,
                                                   1'b1, 6'(i), param_mem[i],
                                                   (i + 1 == give)});
                    end
                end
                frame_ph = sdf_pkg::PH_HUNT0;
            end
            default: begin
                frame_ph = sdf_pkg::PH_HUNT0;
            end
        endcase
    endfunction

    function automatic t_directed_row word_row(input logic [7:0] rx);
        return '{rx, 1'b0, t_deframed'(0)};
    endfunction

    // A word that ends its packet with exactly one result word.
    function automatic t_directed_row closing_row(input logic [7:0] rx, input logic [7:0] id,
                                                  input logic [7:0] err, input logic [5:0] cnt,
                                                  input logic [1:0] st);
        return '{rx, 1'b1, '{id, err, cnt, st, 1'b0, 6'd0, 8'd0, 1'b1}};
    endfunction

    function automatic string show(input t_deframed r);
        return $sformatf("id %h err %h cnt %0d st %0d pv %b idx %0d par %h last %b",
                         r.servo_id, r.error_flags, r.param_count, r.status,
                         r.param_valid, r.param_index, r.param_byte, r.last);
    endfunction

    // Hands one word to the block, with random idle cycles before it, and
    // returns at the edge that accepts it. Valid stays high between words
    // when no idle cycle is drawn.
    task automatic send_byte(input logic [7:0] b);
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(b);
    endtask

    // Stops sending and waits until every owed result word has come, then
    // gives the block time to finish a word that closes no result.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [5:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_shadow = lim;
    endtask

    // Sends one random packet. Most are well formed with random content and
    // a mostly right checksum; the rest are bad lengths, cut-off packets and
    // loose noise. Every word sent adds to counted.
    task automatic send_random_frame(input bit longest, inout int counted);
        logic [7:0] words [$];
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] w;
        int pick;
        int cut;
        int noise;
        pick = longest ? 0 : $urandom_range(99, 0);
        if (pick >= 88) begin
            noise = $urandom_range(4, 1);
            repeat (noise) send_byte(8'($urandom_range(255, 0)));
            counted += noise;
        end else begin
            words = '{sdf_pkg::HDR_BYTE, sdf_pkg::HDR_BYTE};
            if ($urandom_range(9, 0) == 0)
                words.push_back(sdf_pkg::HDR_BYTE);
            words.push_back(8'($urandom_range(254, 0)));
            if (pick >= 70 && pick < 78) begin
                // Length out of bounds, above or below.
                len = $urandom_range(1, 0) ? 8'($urandom_range(255, MAX_LEN + 1))
                                           : 8'($urandom_range(1, 0));
                words.push_back(len);
            end else begin
                len = longest ? 8'(MAX_LEN) : 8'($urandom_range(8, 2));
                sum = words[words.size() - 1];
                // LEN itself, the error word and LEN-2 parameters.
                for (int k = 0; k < len; k++) begin
                    w = (k == 0) ? len : 8'($urandom_range(255, 0));
                    words.push_back(w);
                    sum = sum + w;
                end
                w = sum ^ 8'hFF;
                if ($urandom_range(9, 0) == 0)
                    w = w ^ 8'($urandom_range(255, 1));
                words.push_back(w);
                if (pick >= 78) begin
                    // Cut the packet short; the next packet's words follow on.
                    cut = $urandom_range(words.size() - 1, 3);
                    while (words.size() > cut)
                        void'(words.pop_back());
                end
            end
            foreach (words[i])
                send_byte(words[i]);
            counted += words.size();
        end
    endtask

    // Receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end

    // Every accepted result word is matched with the oldest owed one.
    always @(posedge i_clk) begin : result_check
        t_deframed got;
        t_deframed want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_servo_id, o_error_flags, o_param_count, o_status,
                    o_param_valid, o_param_index, o_param_byte, o_last};
            if (deframed_q.size() == 0) begin
                misses++;
                if (misses <= 10)
                    $display("%0t: result word with none owed: %s", $realtime, show(got));
            end else begin
                want = deframed_q.pop_front();
                if (got !== want) begin
                    misses++;
                    if (misses <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, show(want), show(got));
                end
            end
        end
    end

    // Ends the run if no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int counted;
        int gap_plan   [4];
        int stall_plan [4];
        logic [5:0] lim;
        gap_plan   = '{0, 55, 0, 16};
        stall_plan = '{0, 0, 55, 16};

        // Directed table. It runs with param_limit at its reset value.
        // Noise while hunting, then a lone header word that falls back.
        directed_rows.push_back(word_row(8'h00));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'h00));
        // Length one above the bound is too long.
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'h05));
        directed_rows.push_back(closing_row(8'h3D, 8'h05, 8'h00, 6'd0, sdf_pkg::ST_LONG));
        // An extra header word is swallowed; ID FE with length 1 is too short.
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'hFE));
        directed_rows.push_back(closing_row(8'h01, 8'hFE, 8'h00, 6'd0, sdf_pkg::ST_SHORT));
        // Good packet with no parameters: ID 00, LEN 2, error 80, checksum 7D.
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'h00));
        directed_rows.push_back(word_row(8'h02));
        directed_rows.push_back(word_row(8'h80));
        directed_rows.push_back(closing_row(8'h7D, 8'h00, 8'h80, 6'd0, sdf_pkg::ST_OK));
        // One parameter, checksum off by one (52 would be right).
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'h01));
        directed_rows.push_back(word_row(8'h03));
        directed_rows.push_back(word_row(sdf_pkg::HDR_BYTE));
        directed_rows.push_back(word_row(8'hAA));
        directed_rows.push_back(closing_row(8'h53, 8'h01, 8'hFF, 6'd1, sdf_pkg::ST_BADSUM));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].rx);
            // A typed row closes its packet with one word; the typed value
            // stands in place of the one the shadow worked out.
            if (directed_rows[r].typed) begin
                void'(deframed_q.pop_back());
                deframed_q.push_back(directed_rows[r].want);
            end
        end

        // Random phases. Each starts from an idle block, so the sender
        // pauses here until every owed result word has come back.
        for (int p = 0; p < 4; p++) begin
            settle_block();
            case (p)
                0:       lim = 6'($urandom_range(53, 2)) | 6'd4;
                1:       lim = 6'd0;
                2:       lim = sdf_pkg::LIMIT_RESET;
                default: lim = 6'd1;
            endcase
            write_limit(lim);
            send_gap_pct = gap_plan[p];
            stall_pct    = stall_plan[p];
            counted = 0;
            // One longest packet, its parameters handed out under stalls if its checksum holds.
            if (p == 2)
                send_random_frame(1'b1, counted);
            while (counted < PHASE_WORDS)
                send_random_frame(1'b0, counted);
        end
        settle_block();

        if (misses == 0 && deframed_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
